/* rtl/ssd_pkg.sv */
// ----------------------------------------------------------------------------
// Segment distance package
// Shared widths, types and defaults for the segment-to-segment distance block.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int COORD_W     = 31;   // signed Q15.16 coordinate
    localparam int TOL_W       = 16;   // tolerance register
    localparam int SEP_W       = 32;   // unsigned Q16.16 distance
    localparam int DEPTH_DEF   = 128;  // default result buffer depth

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [SEP_W-1:0] separation;
        logic             touching;
    } ssd_result_t;

endpackage

/* rtl/segment_segment_distance.sv */
// ----------------------------------------------------------------------------
// Segment-to-segment distance
// Shortest distance between two 2D segments in signed Q15.16, with a touch flag.
// ----------------------------------------------------------------------------
// Each input transaction carries two segments, a-b and c-d, as signed Q15.16
// coordinates; each output transaction returns the shortest distance between
// them, floored to unsigned Q16.16, and a touching flag. The segments touch
// when the four orientation cross products show a strict straddle beyond the
// tolerance, or when an endpoint lies on the other segment within it; a
// touching pair reports a distance of zero. Otherwise the distance is the
// least of the four endpoint-to-segment distances, each projected and clamped
// onto the segment, with a segment of squared length at most four Q32.32 units
// treated as a point at its start. The block accepts one transaction per clock
// while in_ready is high. The arithmetic pipeline has seven stages of
// differences, products and decisions, a 64-stage divider giving one quotient
// bit per stage, two stages of minimum and a 32-stage square root giving one
// root bit per stage. Results queue in a buffer of RESULT_DEPTH entries and a
// credit count holds in_ready low once that many transactions are outstanding,
// so a stalled output never loses a result; with the default depth of 128 the
// full rate of one transaction per clock is kept whenever out_ready stays high.
// The tolerance register resets to one and is written through its own
// channel, which is always ready; it is meant to be written only while no
// transaction is outstanding.
module segment_segment_distance
    import ssd_pkg::*;
#(
    parameter int RESULT_DEPTH = DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_ready,
    input  coord_t            first_start_x,
    input  coord_t            first_start_y,
    input  coord_t            first_end_x,
    input  coord_t            first_end_y,
    input  coord_t            second_start_x,
    input  coord_t            second_start_y,
    input  coord_t            second_end_x,
    input  coord_t            second_end_y,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [SEP_W-1:0]  separation,
    output logic              touching,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TOL_W-1:0]  tolerance
);

    localparam int AW = $clog2(RESULT_DEPTH);
    localparam int CW = $clog2(RESULT_DEPTH + 1);

    logic [TOL_W-1:0] tol_reg;

    logic             core_valid;
    ssd_result_t      core_result;

    ssd_result_t      res_mem [RESULT_DEPTH];
    ssd_result_t      out_res_reg;

    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    mem_cnt_reg, mem_cnt_next;
    logic [CW-1:0]    occ_reg, occ_next;
    logic             out_valid_reg, out_valid_next;

    logic             in_acc;
    logic             out_acc;
    logic             load;

    // The tolerance register; the channel never pushes back.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_valid)
        begin
            tol_reg <= tolerance;
        end
    end

    ssd_core u_core
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (in_acc),
        .first_start_x  (first_start_x),
        .first_start_y  (first_start_y),
        .first_end_x    (first_end_x),
        .first_end_y    (first_end_y),
        .second_start_x (second_start_x),
        .second_start_y (second_start_y),
        .second_end_x   (second_end_x),
        .second_end_y   (second_end_y),
        .tolerance      (tol_reg),
        .result_valid   (core_valid),
        .result         (core_result)
    );

    // Every accepted transaction holds a credit until its result has been
    // taken, so the buffer always has room for whatever leaves the pipeline.
    assign in_ready = (occ_reg < CW'(RESULT_DEPTH));
    assign in_acc   = in_valid && in_ready;
    assign out_acc  = out_valid_reg && out_ready;

    // The output register is refilled from the buffer whenever it is empty or
    // its result is being taken in the same cycle.
    assign load = (mem_cnt_reg != '0) && (!out_valid_reg || out_ready);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        if (core_valid)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(RESULT_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        rd_ptr_next = rd_ptr_reg;
        if (load)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(RESULT_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        mem_cnt_next = mem_cnt_reg + CW'(core_valid) - CW'(load);
        occ_next     = occ_reg + CW'(in_acc) - CW'(out_acc);
        priority if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_acc)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            mem_cnt_reg   <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            mem_cnt_reg   <= mem_cnt_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_valid)
        begin
            res_mem[wr_ptr_reg] <= core_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_res_reg <= res_mem[rd_ptr_reg];
        end
    end

    assign out_valid  = out_valid_reg;
    assign separation = out_res_reg.separation;
    assign touching   = out_res_reg.touching;

    // The credit count never runs past the buffer depth.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(RESULT_DEPTH))
        else $error("outstanding transaction count exceeds buffer depth");

    // Buffered results are always a subset of outstanding transactions.
    a_mem_in_credit: assert property (@(posedge clk) disable iff (!rst_n)
        mem_cnt_reg <= occ_reg)
        else $error("buffer holds more results than outstanding transactions");

    // A presented result always belongs to an outstanding transaction.
    a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (occ_reg != '0))
        else $error("result presented with no outstanding transaction");

    // The pipeline never delivers into a full buffer.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        core_valid |-> (mem_cnt_reg < CW'(RESULT_DEPTH)))
        else $error("result buffer overflow");

endmodule

/* rtl/ssd_core.sv */
// ----------------------------------------------------------------------------
// Segment distance arithmetic pipeline
// Cross products, intersection test, per-endpoint squared distances, a
// pipelined long divider, a minimum and a pipelined square root.
// ----------------------------------------------------------------------------
module ssd_core
    import ssd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  coord_t            first_start_x,
    input  coord_t            first_start_y,
    input  coord_t            first_end_x,
    input  coord_t            first_end_y,
    input  coord_t            second_start_x,
    input  coord_t            second_start_y,
    input  coord_t            second_end_x,
    input  coord_t            second_end_y,
    input  logic [TOL_W-1:0]  tolerance,
    output logic              result_valid,
    output ssd_result_t       result
);

    localparam int NPT        = 4;
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 32;
    localparam int DEGEN_LEN2 = 4;

    // Squared-distance slots: 0 = a-c, 1 = a-d, 2 = b-c, 3 = b-d.
    // Points: 0 = a on cd, 1 = b on cd, 2 = c on ab, 3 = d on ab.
    localparam int START_SQ [NPT] = '{0, 2, 0, 1};
    localparam int END_SQ   [NPT] = '{1, 3, 2, 3};

    typedef logic signed [COORD_W:0]   diff_t;
    typedef logic signed [COORD_W+1:0] span_t;
    typedef logic signed [63:0]        wide_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
    } sq_step_t;

    function automatic diff_t sub_c(coord_t p, coord_t q);
        return diff_t'(p) - diff_t'(q);
    endfunction

    function automatic wide_t smul(diff_t x, diff_t y);
        wide_t r;
        r = x * y;
        return r;
    endfunction

    function automatic span_t pos(diff_t v);
        return span_t'(v);
    endfunction

    function automatic span_t neg(diff_t v);
        return -span_t'(v);
    endfunction

    // Point lies within the segment's box widened by the tolerance, on one axis.
    function automatic logic in_span(span_t ds, span_t de, span_t t);
        return ((ds >= -t) || (de >= -t)) && ((ds <= t) || (de <= t));
    endfunction

    function automatic logic [127:0] div_step(logic [127:0] acc, logic [63:0] den);
        logic [64:0] top;
        logic [64:0] dif;
        logic        ge;
        top = acc[127:63];
        dif = top - {1'b0, den};
        ge  = (top >= {1'b0, den});
        return ge ? {dif[63:0], acc[62:0], 1'b1} : {top[63:0], acc[62:0], 1'b0};
    endfunction

    function automatic sq_step_t sqrt_step(logic [33:0] rem, logic [31:0] root,
                                           logic [1:0] pair);
        logic [35:0] rs;
        logic [35:0] tr;
        logic        ge;
        sq_step_t    r;
        rs = {rem, pair};
        tr = {2'b00, root, 2'b01};
        ge = (rs >= tr);
        r.rem  = ge ? 34'(rs - tr) : rs[33:0];
        r.root = {root[30:0], ge};
        return r;
    endfunction

    span_t tol_span;
    wide_t tol_q32;
    assign tol_span = span_t'({1'b0, tolerance});
    assign tol_q32  = wide_t'({32'd0, tolerance, 16'd0});

    // Stage 1: input capture.
    logic   s1_v_reg;
    coord_t s1_ax_reg, s1_ay_reg, s1_bx_reg, s1_by_reg;
    coord_t s1_cx_reg, s1_cy_reg, s1_dx_reg, s1_dy_reg;

    // Stage 2: coordinate differences.
    logic  s2_v_reg;
    diff_t s2_abx_reg, s2_aby_reg, s2_cdx_reg, s2_cdy_reg;
    diff_t s2_acx_reg, s2_acy_reg, s2_adx_reg, s2_ady_reg;
    diff_t s2_cbx_reg, s2_cby_reg, s2_bdx_reg, s2_bdy_reg;

    // Stage 3: products and box tests.
    logic  s3_v_reg;
    wide_t s3_cp_reg [NPT];
    wide_t s3_cq_reg [NPT];
    wide_t s3_dp_reg [NPT];
    wide_t s3_dq_reg [NPT];
    wide_t s3_sx_reg [NPT];
    wide_t s3_sy_reg [NPT];
    wide_t s3_la_reg [2];
    wide_t s3_lb_reg [2];
    logic [NPT-1:0] s3_box_reg;

    // Stage 4: sums.
    logic        s4_v_reg;
    wide_t       s4_cross_reg [NPT];
    wide_t       s4_dot_reg   [NPT];
    logic [63:0] s4_sqd_reg   [NPT];
    wide_t       s4_len_reg   [2];
    logic [NPT-1:0] s4_box_reg;

    // Stage 5: intersection decision and projection case.
    logic           s5_v_reg;
    logic           s5_hit_reg;
    logic [NPT-1:0] s5_int_reg;
    logic [63:0]    s5_sqd_reg [NPT];
    logic [63:0]    s5_mag_reg [NPT];
    logic [63:0]    s5_den_reg [NPT];

    // Stage 6: partial products of the squared cross product.
    logic           s6_v_reg;
    logic           s6_hit_reg;
    logic [NPT-1:0] s6_int_reg;
    logic [63:0]    s6_sqd_reg [NPT];
    logic [63:0]    s6_den_reg [NPT];
    logic [63:0]    s6_hh_reg  [NPT];
    logic [63:0]    s6_hl_reg  [NPT];
    logic [63:0]    s6_ll_reg  [NPT];

    // Divider pipeline; index 0 holds the assembled numerator.
    logic         div_v_reg   [DIV_STEPS+1];
    logic         div_hit_reg [DIV_STEPS+1];
    logic [127:0] div_acc_reg [DIV_STEPS+1][NPT];
    logic [63:0]  div_den_reg [DIV_STEPS+1][NPT];

    // Minimum.
    logic        m1_v_reg;
    logic        m1_hit_reg;
    logic [63:0] m1_min_reg [2];

    // Square root pipeline; index 0 holds the smallest squared distance.
    logic        sq_v_reg    [SQRT_STEPS+1];
    logic        sq_hit_reg  [SQRT_STEPS+1];
    logic [63:0] sq_x_reg    [SQRT_STEPS+1];
    logic [33:0] sq_rem_reg  [SQRT_STEPS+1];
    logic [31:0] sq_root_reg [SQRT_STEPS+1];

    logic        out_v_reg;
    ssd_result_t out_res_reg;

    sq_step_t    sq_next [SQRT_STEPS];

    always_comb
    begin
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            sq_next[k] = sqrt_step(sq_rem_reg[k], sq_root_reg[k], sq_x_reg[k][63:62]);
        end
    end

    // Valid bits travel with the data; the pipeline never stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            m1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                div_v_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= SQRT_STEPS; k++)
            begin
                sq_v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            s1_v_reg     <= item_valid;
            s2_v_reg     <= s1_v_reg;
            s3_v_reg     <= s2_v_reg;
            s4_v_reg     <= s3_v_reg;
            s5_v_reg     <= s4_v_reg;
            s6_v_reg     <= s5_v_reg;
            div_v_reg[0] <= s6_v_reg;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                div_v_reg[k+1] <= div_v_reg[k];
            end
            m1_v_reg    <= div_v_reg[DIV_STEPS];
            sq_v_reg[0] <= m1_v_reg;
            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
            out_v_reg <= sq_v_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        // Stage 1.
        s1_ax_reg <= first_start_x;
        s1_ay_reg <= first_start_y;
        s1_bx_reg <= first_end_x;
        s1_by_reg <= first_end_y;
        s1_cx_reg <= second_start_x;
        s1_cy_reg <= second_start_y;
        s1_dx_reg <= second_end_x;
        s1_dy_reg <= second_end_y;

        // Stage 2.
        s2_abx_reg <= sub_c(s1_bx_reg, s1_ax_reg);
        s2_aby_reg <= sub_c(s1_by_reg, s1_ay_reg);
        s2_cdx_reg <= sub_c(s1_dx_reg, s1_cx_reg);
        s2_cdy_reg <= sub_c(s1_dy_reg, s1_cy_reg);
        s2_acx_reg <= sub_c(s1_cx_reg, s1_ax_reg);
        s2_acy_reg <= sub_c(s1_cy_reg, s1_ay_reg);
        s2_adx_reg <= sub_c(s1_dx_reg, s1_ax_reg);
        s2_ady_reg <= sub_c(s1_dy_reg, s1_ay_reg);
        s2_cbx_reg <= sub_c(s1_bx_reg, s1_cx_reg);
        s2_cby_reg <= sub_c(s1_by_reg, s1_cy_reg);
        s2_bdx_reg <= sub_c(s1_bx_reg, s1_dx_reg);
        s2_bdy_reg <= sub_c(s1_by_reg, s1_dy_reg);

        // Stage 3: cross product halves, one orientation per point.
        s3_cp_reg[0] <= smul(s2_cdy_reg, s2_acx_reg);
        s3_cq_reg[0] <= smul(s2_cdx_reg, s2_acy_reg);
        s3_cp_reg[1] <= smul(s2_cdx_reg, s2_cby_reg);
        s3_cq_reg[1] <= smul(s2_cdy_reg, s2_cbx_reg);
        s3_cp_reg[2] <= smul(s2_abx_reg, s2_acy_reg);
        s3_cq_reg[2] <= smul(s2_aby_reg, s2_acx_reg);
        s3_cp_reg[3] <= smul(s2_abx_reg, s2_ady_reg);
        s3_cq_reg[3] <= smul(s2_aby_reg, s2_adx_reg);

        s3_dp_reg[0] <= smul(s2_acx_reg, s2_cdx_reg);
        s3_dq_reg[0] <= smul(s2_acy_reg, s2_cdy_reg);
        s3_dp_reg[1] <= smul(s2_cbx_reg, s2_cdx_reg);
        s3_dq_reg[1] <= smul(s2_cby_reg, s2_cdy_reg);
        s3_dp_reg[2] <= smul(s2_acx_reg, s2_abx_reg);
        s3_dq_reg[2] <= smul(s2_acy_reg, s2_aby_reg);
        s3_dp_reg[3] <= smul(s2_adx_reg, s2_abx_reg);
        s3_dq_reg[3] <= smul(s2_ady_reg, s2_aby_reg);

        s3_sx_reg[0] <= smul(s2_acx_reg, s2_acx_reg);
        s3_sy_reg[0] <= smul(s2_acy_reg, s2_acy_reg);
        s3_sx_reg[1] <= smul(s2_adx_reg, s2_adx_reg);
        s3_sy_reg[1] <= smul(s2_ady_reg, s2_ady_reg);
        s3_sx_reg[2] <= smul(s2_cbx_reg, s2_cbx_reg);
        s3_sy_reg[2] <= smul(s2_cby_reg, s2_cby_reg);
        s3_sx_reg[3] <= smul(s2_bdx_reg, s2_bdx_reg);
        s3_sy_reg[3] <= smul(s2_bdy_reg, s2_bdy_reg);

        s3_la_reg[0] <= smul(s2_cdx_reg, s2_cdx_reg);
        s3_lb_reg[0] <= smul(s2_cdy_reg, s2_cdy_reg);
        s3_la_reg[1] <= smul(s2_abx_reg, s2_abx_reg);
        s3_lb_reg[1] <= smul(s2_aby_reg, s2_aby_reg);

        s3_box_reg[0] <= in_span(neg(s2_acx_reg), neg(s2_adx_reg), tol_span)
                      && in_span(neg(s2_acy_reg), neg(s2_ady_reg), tol_span);
        s3_box_reg[1] <= in_span(pos(s2_cbx_reg), pos(s2_bdx_reg), tol_span)
                      && in_span(pos(s2_cby_reg), pos(s2_bdy_reg), tol_span);
        s3_box_reg[2] <= in_span(pos(s2_acx_reg), neg(s2_cbx_reg), tol_span)
                      && in_span(pos(s2_acy_reg), neg(s2_cby_reg), tol_span);
        s3_box_reg[3] <= in_span(pos(s2_adx_reg), neg(s2_bdx_reg), tol_span)
                      && in_span(pos(s2_ady_reg), neg(s2_bdy_reg), tol_span);

        // Stage 4. The first point's dot product runs against the segment.
        for (int k = 0; k < NPT; k++)
        begin
            s4_cross_reg[k] <= s3_cp_reg[k] - s3_cq_reg[k];
            s4_sqd_reg[k]   <= $unsigned(s3_sx_reg[k] + s3_sy_reg[k]);
        end
        s4_dot_reg[0] <= wide_t'(0) - s3_dp_reg[0] - s3_dq_reg[0];
        for (int k = 1; k < NPT; k++)
        begin
            s4_dot_reg[k] <= s3_dp_reg[k] + s3_dq_reg[k];
        end
        s4_len_reg[0] <= s3_la_reg[0] + s3_lb_reg[0];
        s4_len_reg[1] <= s3_la_reg[1] + s3_lb_reg[1];
        s4_box_reg    <= s3_box_reg;

        // Stage 5. Points 2 and 3 carry the orientations of c and d against ab,
        // points 0 and 1 those of a and b against cd.
        s5_hit_reg <= (((s4_cross_reg[2] > tol_q32) && (s4_cross_reg[3] < -tol_q32))
                    || ((s4_cross_reg[2] < -tol_q32) && (s4_cross_reg[3] > tol_q32)))
                    && (((s4_cross_reg[0] > tol_q32) && (s4_cross_reg[1] < -tol_q32))
                    || ((s4_cross_reg[0] < -tol_q32) && (s4_cross_reg[1] > tol_q32)))
                    || (s4_box_reg[0] && (s4_cross_reg[0] <= tol_q32)
                        && (s4_cross_reg[0] >= -tol_q32))
                    || (s4_box_reg[1] && (s4_cross_reg[1] <= tol_q32)
                        && (s4_cross_reg[1] >= -tol_q32))
                    || (s4_box_reg[2] && (s4_cross_reg[2] <= tol_q32)
                        && (s4_cross_reg[2] >= -tol_q32))
                    || (s4_box_reg[3] && (s4_cross_reg[3] <= tol_q32)
                        && (s4_cross_reg[3] >= -tol_q32));
        for (int k = 0; k < NPT; k++)
        begin
            // A degenerate segment or a projection before the start uses the
            // start; one beyond the end uses the end.
            if ((s4_len_reg[k/2] <= wide_t'(DEGEN_LEN2)) || (s4_dot_reg[k] <= wide_t'(0)))
            begin
                s5_int_reg[k] <= 1'b0;
                s5_sqd_reg[k] <= s4_sqd_reg[START_SQ[k]];
            end
            else if (s4_dot_reg[k] >= s4_len_reg[k/2])
            begin
                s5_int_reg[k] <= 1'b0;
                s5_sqd_reg[k] <= s4_sqd_reg[END_SQ[k]];
            end
            else
            begin
                s5_int_reg[k] <= 1'b1;
                s5_sqd_reg[k] <= s4_sqd_reg[START_SQ[k]];
            end
            s5_mag_reg[k] <= (s4_cross_reg[k] < wide_t'(0)) ? $unsigned(-s4_cross_reg[k])
                                                              : $unsigned(s4_cross_reg[k]);
            s5_den_reg[k] <= $unsigned(s4_len_reg[k/2]);
        end

        // Stage 6.
        s6_hit_reg <= s5_hit_reg;
        s6_int_reg <= s5_int_reg;
        for (int k = 0; k < NPT; k++)
        begin
            s6_sqd_reg[k] <= s5_sqd_reg[k];
            s6_den_reg[k] <= s5_den_reg[k];
            s6_hh_reg[k]  <= s5_mag_reg[k][63:32] * s5_mag_reg[k][63:32];
            s6_hl_reg[k]  <= s5_mag_reg[k][63:32] * s5_mag_reg[k][31:0];
            s6_ll_reg[k]  <= s5_mag_reg[k][31:0]  * s5_mag_reg[k][31:0];
        end

        // Numerator and denominator; endpoint cases divide by one.
        div_hit_reg[0] <= s6_hit_reg;
        for (int k = 0; k < NPT; k++)
        begin
            if (s6_int_reg[k])
            begin
                div_acc_reg[0][k] <= {s6_hh_reg[k], s6_ll_reg[k]}
                                   + {31'd0, s6_hl_reg[k], 33'd0};
                div_den_reg[0][k] <= s6_den_reg[k];
            end
            else
            begin
                div_acc_reg[0][k] <= {64'd0, s6_sqd_reg[k]};
                div_den_reg[0][k] <= 64'd1;
            end
        end

        // One quotient bit per stage.
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            div_hit_reg[s+1] <= div_hit_reg[s];
            for (int k = 0; k < NPT; k++)
            begin
                div_acc_reg[s+1][k] <= div_step(div_acc_reg[s][k], div_den_reg[s][k]);
                div_den_reg[s+1][k] <= div_den_reg[s][k];
            end
        end

        // The root is monotonic, so the minimum is taken on squared values.
        m1_hit_reg    <= div_hit_reg[DIV_STEPS];
        m1_min_reg[0] <= (div_acc_reg[DIV_STEPS][1][63:0] < div_acc_reg[DIV_STEPS][0][63:0])
                       ? div_acc_reg[DIV_STEPS][1][63:0] : div_acc_reg[DIV_STEPS][0][63:0];
        m1_min_reg[1] <= (div_acc_reg[DIV_STEPS][3][63:0] < div_acc_reg[DIV_STEPS][2][63:0])
                       ? div_acc_reg[DIV_STEPS][3][63:0] : div_acc_reg[DIV_STEPS][2][63:0];

        sq_hit_reg[0]  <= m1_hit_reg;
        sq_x_reg[0]    <= (m1_min_reg[1] < m1_min_reg[0]) ? m1_min_reg[1] : m1_min_reg[0];
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;

        // One root bit per stage.
        for (int s = 0; s < SQRT_STEPS; s++)
        begin
            sq_hit_reg[s+1]  <= sq_hit_reg[s];
            sq_x_reg[s+1]    <= {sq_x_reg[s][61:0], 2'b00};
            sq_rem_reg[s+1]  <= sq_next[s].rem;
            sq_root_reg[s+1] <= sq_next[s].root;
        end

        out_res_reg.touching   <= sq_hit_reg[SQRT_STEPS];
        out_res_reg.separation <= sq_hit_reg[SQRT_STEPS] ? '0 : sq_root_reg[SQRT_STEPS];
    end

    assign result_valid = out_v_reg;
    assign result       = out_res_reg;

endmodule
